>>> hdl/page_fault_frame_replacer_top_macros.svh
// Assertion macros for the page fault frame replacer.
// Included by the modules that check their own control; needs clock and reset in scope.
`ifndef PAGE_FAULT_FRAME_REPLACER_TOP_MACROS_SVH
`define PAGE_FAULT_FRAME_REPLACER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PFFR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define PFFR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/pffr_pkg.sv
// Shared constants, codes and port bundles for the page fault frame replacer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package pffr_pkg;

   localparam int NUM_PAGES  = 256;
   localparam int NUM_FRAMES = 64;
   localparam int PAGE_W     = $clog2(NUM_PAGES);
   localparam int FRAME_W    = $clog2(NUM_FRAMES);
   localparam int COUNT_W    = FRAME_W + 1;
   localparam int PERM_W     = 2;
   localparam int PTE_W      = FRAME_W + PERM_W;
   localparam int SEED_W     = 32;
   localparam int ACTION_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int STEP_W     = $clog2(SEED_W + 1);

   localparam logic [SEED_W-1:0] LFSR_MASK = 32'h8020_0003;

   // Permission encodings: bit 0 read, bit 1 write
   localparam logic [PERM_W-1:0] PERM_NONE  = 2'b00;
   localparam logic [PERM_W-1:0] PERM_READ  = 2'b01;
   localparam logic [PERM_W-1:0] PERM_RDWR  = 2'b11;

   localparam logic [ACTION_W-1:0] ACT_GRANT_WRITE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_GRANT_READ  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD_FREE   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_REPLACE     = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAMES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SEED   = 2'd2;

   localparam logic POLICY_RANDOM = 1'b0;
   localparam logic POLICY_FIFO   = 1'b1;

   typedef struct packed {
      logic              rd_en;
      logic [PAGE_W-1:0] rd_addr;
      logic              wr_en;
      logic [PAGE_W-1:0] wr_addr;
      logic [PTE_W-1:0]  wr_data;
   } pt_req_type;

   typedef struct packed {
      logic               rd_en;
      logic [FRAME_W-1:0] rd_addr;
      logic               wr_owner;
      logic               wr_ring;
      logic [FRAME_W-1:0] wr_addr;
      logic [PAGE_W-1:0]  owner_data;
      logic [FRAME_W-1:0] ring_data;
   } fm_req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  owner;
      logic [FRAME_W-1:0] ring;
   } fm_rsp_type;

   typedef struct packed {
      logic               start;
      logic               short_op;
      logic [SEED_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic               done;
      logic [FRAME_W-1:0] rem;
   } mod_sts_type;

endpackage

>>> hdl/pffr_page_table.sv
// Page table memory: frame number and permissions per virtual page.
// Synchronous read, one write port; per-entry flags make unwritten entries read as zero.
`timescale 1ns / 1ps

module pffr_page_table import pffr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  pt_req_type       req,
   output logic [PTE_W-1:0] rd_data
);

   logic [PTE_W-1:0]     mem [NUM_PAGES];
   logic [NUM_PAGES-1:0] filled_ff;
   logic [PTE_W-1:0]     data_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         data_ff <= mem[req.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         if (req.wr_en) begin
            filled_ff[req.wr_addr] <= 1'b1;
         end
         if (req.rd_en) begin
            hit_ff <= filled_ff[req.rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

>>> hdl/pffr_frame_table.sv
// Frame table memory: owner page per frame and the FIFO ring of frames, same addressing.
// Synchronous read of both fields; each field has its own write enable.
`timescale 1ns / 1ps

module pffr_frame_table import pffr_pkg::*; (
   input  logic       clock,
   input  fm_req_type req,
   output fm_rsp_type rd_data
);

   logic [PAGE_W-1:0]  owner_mem [NUM_FRAMES];
   logic [FRAME_W-1:0] ring_mem  [NUM_FRAMES];
   fm_rsp_type         data_ff;

   always_ff @(posedge clock) begin
      if (req.wr_owner) begin
         owner_mem[req.wr_addr] <= req.owner_data;
      end
      if (req.wr_ring) begin
         ring_mem[req.wr_addr] <= req.ring_data;
      end
      if (req.rd_en) begin
         data_ff.owner <= owner_mem[req.rd_addr];
         data_ff.ring  <= ring_mem[req.rd_addr];
      end
   end

   assign rd_data = data_ff;

endmodule

>>> hdl/pffr_mod.sv
// Bit-serial remainder unit: dividend modulo the active frame count, one bit per cycle.
// Short operations take the low COUNT_W bits only; uses pffr_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "page_fault_frame_replacer_top_macros.svh"

module pffr_mod import pffr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mod_req_type req,
   output mod_sts_type sts
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic [SEED_W-1:0]  dvd_ff, dvd_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [FRAME_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] trial;

   // Remainder stays below the divisor, so the shifted value fits COUNT_W bits
   assign trial = {rem_ff, dvd_ff[SEED_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         div_in  = req.divisor;
         rem_in  = '0;
         if (req.short_op) begin
            cnt_in = STEP_W'(COUNT_W);
            dvd_in = {req.dividend[COUNT_W-1:0], {(SEED_W-COUNT_W){1'b0}}};
         end else begin
            cnt_in = STEP_W'(SEED_W);
            dvd_in = req.dividend;
         end
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[SEED_W-2:0], 1'b0};
         if (trial >= div_ff) begin
            rem_in = FRAME_W'(trial - div_ff);
         end else begin
            rem_in = FRAME_W'(trial);
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign sts.done = done_ff;
   assign sts.rem  = rem_ff;

   `PFFR_ASSERT_NOW(a_mod_no_restart, req.start, !busy_ff, "remainder unit restarted while busy")
   `PFFR_ASSERT_NEXT(a_mod_start_busy, req.start, busy_ff, "remainder unit did not start")
   `PFFR_ASSERT_NOW(a_mod_rem_range, done_ff, {1'b0, rem_ff} < div_ff, "remainder not below divisor")

endmodule

>>> hdl/page_fault_frame_replacer_top.sv
// Page fault handler with FIFO or random frame replacement; top level and sequencer.
// Uses pffr_pkg, pffr_page_table, pffr_frame_table, pffr_mod and the assertion macros.
// One fault at a time; the next is taken in the idle state, which the sequencer enters as the
// result is registered. The serial remainder unit (7 steps for ring pointers, 32 for the random
// draw) serves FIFO ring updates and random replacements.
// Reset is synchronous: page table flags clear at once, no clearing pass is needed.
`timescale 1ns / 1ps
`include "page_fault_frame_replacer_top_macros.svh"

module page_fault_frame_replacer_top import pffr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [PAGE_W-1:0]    req_fault_page,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [ACTION_W-1:0]  rsp_action,
   output logic [FRAME_W-1:0]   rsp_frame,
   output logic                 rsp_perm_read,
   output logic                 rsp_perm_write,
   output logic                 rsp_load_from_disk,
   output logic [PAGE_W-1:0]    rsp_victim_page,
   output logic                 rsp_victim_writeback,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEED_W-1:0]    csr_data
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LOOK   = 4'd1;
   localparam logic [3:0] S_MOD    = 4'd2;
   localparam logic [3:0] S_OWNER  = 4'd3;
   localparam logic [3:0] S_VICTIM = 4'd4;
   localparam logic [3:0] S_EVICT  = 4'd5;
   localparam logic [3:0] S_MAP    = 4'd6;
   localparam logic [3:0] S_OUT    = 4'd7;

   logic [3:0]          state_ff, state_in;
   logic                policy_ff, policy_in;
   logic [COUNT_W-1:0]  frames_ff, frames_in;
   logic [SEED_W-1:0]   lfsr_ff, lfsr_in;
   logic [COUNT_W-1:0]  alloc_ff, alloc_in;
   logic [FRAME_W-1:0]  head_ff, head_in;
   logic [FRAME_W-1:0]  tail_ff, tail_in;
   logic                repl_ff, repl_in;

   logic [PAGE_W-1:0]   page_ff, page_in;
   logic [FRAME_W-1:0]  frame_ff, frame_in;
   logic [PAGE_W-1:0]   vpage_ff, vpage_in;
   logic                wb_ff, wb_in;
   logic [ACTION_W-1:0] action_ff, action_in;
   logic [PERM_W-1:0]   perm_ff, perm_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [ACTION_W-1:0] rsp_action_ff;
   logic [FRAME_W-1:0]  rsp_frame_ff;
   logic [PERM_W-1:0]   rsp_perm_ff;
   logic [PAGE_W-1:0]   rsp_vpage_ff;
   logic                rsp_wb_ff;
   logic                rsp_load;

   logic [COUNT_W-1:0]  count;
   logic [SEED_W-1:0]   lfsr_next;
   logic [PTE_W-1:0]    pt_rd_data;
   logic [PERM_W-1:0]   cur_perm;
   logic [FRAME_W-1:0]  cur_frame;
   pt_req_type          pt_req;
   fm_req_type          fm_req;
   fm_rsp_type          fm_rd_data;
   mod_req_type         mod_req;
   mod_sts_type         mod_sts;

   pffr_page_table u_page_table (
      .clock   (clock),
      .reset   (reset),
      .req     (pt_req),
      .rd_data (pt_rd_data)
   );

   pffr_frame_table u_frame_table (
      .clock   (clock),
      .req     (fm_req),
      .rd_data (fm_rd_data)
   );

   pffr_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .sts   (mod_sts)
   );

   // Active frame count, clamped to 1..NUM_FRAMES
   always_comb begin
      if (frames_ff == '0) begin
         count = COUNT_W'(1);
      end else if (frames_ff > COUNT_W'(NUM_FRAMES)) begin
         count = COUNT_W'(NUM_FRAMES);
      end else begin
         count = frames_ff;
      end
   end

   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_MASK) : (lfsr_ff >> 1);
   assign cur_perm  = pt_rd_data[PERM_W-1:0];
   assign cur_frame = pt_rd_data[PTE_W-1:PERM_W];
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_load  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      frames_in    = frames_ff;
      lfsr_in      = lfsr_ff;
      alloc_in     = alloc_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      repl_in      = repl_ff;
      page_in      = page_ff;
      frame_in     = frame_ff;
      vpage_in     = vpage_ff;
      wb_in        = wb_ff;
      action_in    = action_ff;
      perm_in      = perm_ff;
      rsp_valid_in = rsp_valid_ff;

      pt_req         = '0;
      pt_req.rd_addr = req_fault_page;
      fm_req         = '0;
      mod_req        = '0;
      mod_req.divisor = count;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            pt_req.rd_en = 1'b1;
            if (req_valid) begin
               page_in  = req_fault_page;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            vpage_in = '0;
            wb_in    = 1'b0;
            if (cur_perm == PERM_READ) begin
               action_in      = ACT_GRANT_WRITE;
               perm_in        = PERM_RDWR;
               frame_in       = cur_frame;
               pt_req.wr_en   = 1'b1;
               pt_req.wr_addr = page_ff;
               pt_req.wr_data = {cur_frame, PERM_RDWR};
               state_in       = S_OUT;
            end else if (cur_perm != PERM_NONE) begin
               action_in      = ACT_GRANT_READ;
               perm_in        = cur_perm | PERM_READ;
               frame_in       = cur_frame;
               pt_req.wr_en   = 1'b1;
               pt_req.wr_addr = page_ff;
               pt_req.wr_data = {cur_frame, cur_perm | PERM_READ};
               state_in       = S_OUT;
            end else if (alloc_ff < count) begin
               // Frames fill in ascending order, so the lowest free one is the fill count
               action_in = ACT_LOAD_FREE;
               perm_in   = PERM_READ;
               frame_in  = alloc_ff[FRAME_W-1:0];
               alloc_in  = alloc_ff + 1'b1;
               repl_in   = 1'b0;
               if (policy_ff == POLICY_FIFO) begin
                  fm_req.wr_ring   = 1'b1;
                  fm_req.wr_addr   = tail_ff;
                  fm_req.ring_data = alloc_ff[FRAME_W-1:0];
                  mod_req.start    = 1'b1;
                  mod_req.short_op = 1'b1;
                  mod_req.dividend = SEED_W'({1'b0, tail_ff} + 1'b1);
                  state_in         = S_MOD;
               end else begin
                  state_in = S_MAP;
               end
            end else begin
               action_in     = ACT_REPLACE;
               perm_in       = PERM_READ;
               repl_in       = 1'b1;
               mod_req.start = 1'b1;
               if (policy_ff == POLICY_FIFO) begin
                  fm_req.rd_en     = 1'b1;
                  fm_req.rd_addr   = head_ff;
                  mod_req.short_op = 1'b1;
                  mod_req.dividend = SEED_W'({1'b0, head_ff} + 1'b1);
               end else begin
                  lfsr_in          = lfsr_next;
                  mod_req.dividend = lfsr_next;
               end
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            if (mod_sts.done) begin
               if (!repl_ff) begin
                  tail_in  = mod_sts.rem;
                  state_in = S_MAP;
               end else begin
                  // Ring read data is still held from the lookup cycle
                  if (policy_ff == POLICY_FIFO) begin
                     frame_in = fm_rd_data.ring;
                     head_in  = mod_sts.rem;
                  end else begin
                     frame_in = mod_sts.rem;
                  end
                  state_in = S_OWNER;
               end
            end
         end
         S_OWNER: begin
            fm_req.rd_en   = 1'b1;
            fm_req.rd_addr = frame_ff;
            state_in       = S_VICTIM;
         end
         S_VICTIM: begin
            vpage_in       = fm_rd_data.owner;
            pt_req.rd_en   = 1'b1;
            pt_req.rd_addr = fm_rd_data.owner;
            state_in       = S_EVICT;
         end
         S_EVICT: begin
            wb_in          = cur_perm[1];
            pt_req.wr_en   = 1'b1;
            pt_req.wr_addr = vpage_ff;
            pt_req.wr_data = '0;
            state_in       = S_MAP;
         end
         S_MAP: begin
            pt_req.wr_en      = 1'b1;
            pt_req.wr_addr    = page_ff;
            pt_req.wr_data    = {frame_ff, PERM_READ};
            fm_req.wr_owner   = 1'b1;
            fm_req.wr_addr    = frame_ff;
            fm_req.owner_data = page_ff;
            state_in          = S_OUT;
         end
         S_OUT: begin
            // Hold until the output register is free
            if (rsp_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_POLICY: policy_in = csr_data[0];
            CSR_FRAMES: frames_in = csr_data[COUNT_W-1:0];
            CSR_SEED:   lfsr_in   = (csr_data == '0) ? SEED_W'(1) : csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         policy_ff    <= POLICY_FIFO;
         frames_ff    <= COUNT_W'(NUM_FRAMES);
         lfsr_ff      <= SEED_W'(1);
         alloc_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         repl_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         frames_ff    <= frames_in;
         lfsr_ff      <= lfsr_in;
         alloc_ff     <= alloc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         repl_ff      <= repl_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      frame_ff  <= frame_in;
      vpage_ff  <= vpage_in;
      wb_ff     <= wb_in;
      action_ff <= action_in;
      perm_ff   <= perm_in;
      if (state_ff == S_OUT && rsp_load) begin
         rsp_action_ff <= action_ff;
         rsp_frame_ff  <= frame_ff;
         rsp_perm_ff   <= perm_ff;
         rsp_vpage_ff  <= vpage_ff;
         rsp_wb_ff     <= wb_ff;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_action           = rsp_action_ff;
   assign rsp_frame            = rsp_frame_ff;
   assign rsp_perm_read        = rsp_perm_ff[0];
   assign rsp_perm_write       = rsp_perm_ff[1];
   assign rsp_load_from_disk   = rsp_action_ff[1];
   assign rsp_victim_page      = rsp_vpage_ff;
   assign rsp_victim_writeback = rsp_wb_ff;

   `PFFR_ASSERT_NEXT(a_accept_to_look, req_valid && !req_stall, state_ff == S_LOOK, "transfer did not start lookup")
   `PFFR_ASSERT_NOW(a_alloc_bound, 1'b1, alloc_ff <= COUNT_W'(NUM_FRAMES), "fill count beyond frame count")
   `PFFR_ASSERT_NOW(a_mod_done_state, mod_sts.done, state_ff == S_MOD, "remainder done outside wait state")
   `PFFR_ASSERT_NOW(a_map_is_load, state_ff == S_MAP, action_ff[1], "mapping step for a grant action")

endmodule

>>> verif/page_fault_frame_replacer_top_test.sv
// Self-checking bench for page_fault_frame_replacer_top: drives page faults, programs the
// CSRs between phases and checks every outcome against an in-bench model of the handler.
// Depends on pffr_pkg and the page_fault_frame_replacer_top RTL only.
`timescale 1ns / 1ps

module page_fault_frame_replacer_top_test;
   import pffr_pkg::*;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [FRAME_W-1:0]  frame;
      logic                perm_read;
      logic                perm_write;
      logic                disk_load;
      logic [PAGE_W-1:0]   victim;
      logic                writeback;
   } fault_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PAGE_W-1:0]    req_fault_page = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [ACTION_W-1:0]  rsp_action;
   logic [FRAME_W-1:0]   rsp_frame;
   logic                 rsp_perm_read;
   logic                 rsp_perm_write;
   logic                 rsp_load_from_disk;
   logic [PAGE_W-1:0]    rsp_victim_page;
   logic                 rsp_victim_writeback;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_POLICY;
   logic [SEED_W-1:0]    csr_data = '0;

   page_fault_frame_replacer_top dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow of the handler state
   logic [FRAME_W-1:0] page_frame [NUM_PAGES];
   logic [PERM_W-1:0]  page_perm  [NUM_PAGES];
   logic               frame_taken [NUM_FRAMES];
   logic [PAGE_W-1:0]  frame_page  [NUM_FRAMES];
   logic [FRAME_W-1:0] evict_ring  [NUM_FRAMES];
   bit                 ring_filled [NUM_FRAMES];
   int unsigned        ring_rd;
   int unsigned        ring_wr;
   logic [SEED_W-1:0]  draw_reg;
   logic               cfg_policy;
   logic [COUNT_W-1:0] cfg_frames;

   logic [PAGE_W-1:0]  pending_faults[$];
   fault_outcome_type  queued_outcomes[$];
   fault_outcome_type  owed_outcomes[$];

   int unsigned error_count = 0;
   int unsigned outcomes_seen = 0;
   int unsigned send_wait;
   int unsigned hold_left;
   bit          send_calm = 1'b0;
   bit          take_calm = 1'b0;

   function automatic void clear_model();
      for (int p = 0; p < NUM_PAGES; p++) begin
         page_frame[p] = '0;
         page_perm[p]  = PERM_NONE;
      end
      for (int f = 0; f < NUM_FRAMES; f++) begin
         frame_taken[f] = 1'b0;
         frame_page[f]  = '0;
         evict_ring[f]  = '0;
         ring_filled[f] = 1'b0;
      end
      ring_rd    = 0;
      ring_wr    = 0;
      cfg_policy = POLICY_FIFO;
      cfg_frames = COUNT_W'(NUM_FRAMES);
      draw_reg   = 1;
   endfunction

   function automatic void apply_csr(logic [CSR_IDX_W-1:0] idx, logic [SEED_W-1:0] data);
      case (idx)
         CSR_POLICY: cfg_policy = data[0];
         CSR_FRAMES: cfg_frames = data[COUNT_W-1:0];
         CSR_SEED:   draw_reg   = (data == '0) ? SEED_W'(1) : data;
         default: ;
      endcase
   endfunction

   function automatic int unsigned frame_limit();
      if (cfg_frames == 0) return 1;
      if (cfg_frames > NUM_FRAMES) return NUM_FRAMES;
      return 32'(cfg_frames);
   endfunction

   function automatic bit free_frame_left();
      for (int unsigned f = 0; f < frame_limit(); f++)
         if (!frame_taken[f]) return 1'b1;
      return 1'b0;
   endfunction

   function automatic fault_outcome_type resolve_fault(logic [PAGE_W-1:0] page);
      fault_outcome_type r;
      int unsigned       n;
      bit                found;
      logic [PAGE_W-1:0] old;
      r = '0;
      n = frame_limit();
      if (page_perm[page] == PERM_READ) begin
         r.action        = ACT_GRANT_WRITE;
         page_perm[page] = PERM_RDWR;
         r.frame         = page_frame[page];
      end else if (page_perm[page] != PERM_NONE) begin
         r.action        = ACT_GRANT_READ;
         page_perm[page] = page_perm[page] | PERM_READ;
         r.frame         = page_frame[page];
      end else begin
         found = 1'b0;
         for (int unsigned f = 0; f < n && !found; f++) begin
            if (!frame_taken[f]) begin
               r.frame = FRAME_W'(f);
               found   = 1'b1;
            end
         end
         r.disk_load = 1'b1;
         if (found) begin
            r.action = ACT_LOAD_FREE;
            frame_taken[r.frame] = 1'b1;
            if (cfg_policy == POLICY_FIFO) begin
               evict_ring[ring_wr % NUM_FRAMES]  = r.frame;
               ring_filled[ring_wr % NUM_FRAMES] = 1'b1;
               ring_wr = (ring_wr + 1) % n;
            end
         end else begin
            r.action = ACT_REPLACE;
            if (cfg_policy == POLICY_FIFO) begin
               r.frame = evict_ring[ring_rd % NUM_FRAMES];
               ring_rd = (ring_rd + 1) % n;
            end else begin
               // step the Galois register once per random eviction
               draw_reg = draw_reg[0] ? ((draw_reg >> 1) ^ LFSR_MASK) : (draw_reg >> 1);
               r.frame  = FRAME_W'(draw_reg % n);
            end
            old             = frame_page[r.frame];
            r.victim        = old;
            r.writeback     = page_perm[old][1];
            page_perm[old]  = PERM_NONE;
            page_frame[old] = '0;
         end
         page_frame[page]    = r.frame;
         page_perm[page]     = PERM_READ;
         frame_page[r.frame] = page;
      end
      r.perm_read  = page_perm[page][0];
      r.perm_write = page_perm[page][1];
      return r;
   endfunction

   // Refuse a fault that would make a FIFO eviction read a ring slot never filled
   function automatic bit try_fault(logic [PAGE_W-1:0] page);
      if (page_perm[page] == PERM_NONE && !free_frame_left() && cfg_policy == POLICY_FIFO
          && !ring_filled[ring_rd % NUM_FRAMES])
         return 1'b0;
      pending_faults.push_back(page);
      queued_outcomes.push_back(resolve_fault(page));
      return 1'b1;
   endfunction

   function automatic logic [PAGE_W-1:0] pick_page(int unsigned span);
      if ($urandom_range(0, 2) == 0) return PAGE_W'($urandom_range(0, NUM_PAGES - 1));
      return PAGE_W'($urandom_range(0, span));
   endfunction

   task automatic random_faults(int unsigned count, int unsigned span);
      int unsigned added;
      int unsigned tries;
      added = 0;
      tries = 0;
      while (added < count && tries < count * 50) begin
         if (try_fault(pick_page(span))) added++;
         tries++;
      end
   endtask

   function automatic int unsigned draw_wait(bit calm);
      return calm ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic note_error(string msg);
      error_count++;
      $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   task automatic compare_field(string name, int unsigned got, int unsigned want);
      if (got != want)
         note_error($sformatf("outcome %0d: %s is %0d, expected %0d",
                              outcomes_seen, name, got, want));
   endtask

   task automatic check_outcome();
      fault_outcome_type want;
      if (owed_outcomes.size() == 0) begin
         note_error($sformatf("outcome with no fault outstanding (action %0d frame %0d)",
                              rsp_action, rsp_frame));
         return;
      end
      want = owed_outcomes.pop_front();
      compare_field("action", 32'(rsp_action), 32'(want.action));
      compare_field("frame", 32'(rsp_frame), 32'(want.frame));
      compare_field("perm_read", 32'(rsp_perm_read), 32'(want.perm_read));
      compare_field("perm_write", 32'(rsp_perm_write), 32'(want.perm_write));
      compare_field("load_from_disk", 32'(rsp_load_from_disk), 32'(want.disk_load));
      compare_field("victim_page", 32'(rsp_victim_page), 32'(want.victim));
      compare_field("victim_writeback", 32'(rsp_victim_writeback), 32'(want.writeback));
      outcomes_seen++;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SEED_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_data         <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      apply_csr(idx, data);
   endtask

   task automatic drain(int unsigned tail_cycles);
      while (pending_faults.size() != 0 || req_valid || queued_outcomes.size() != 0
             || owed_outcomes.size() != 0)
         @(negedge clock);
      repeat (tail_cycles) @(negedge clock);
   endtask

   // Fault driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = draw_wait(send_calm);
      end else begin
         if (req_valid && !req_stall) begin
            if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
            send_wait = draw_wait(send_calm);
         end
         if (!req_valid || !req_stall) begin
            if (send_wait == 0 && pending_faults.size() != 0) begin
               req_valid      <= 1'b1;
               req_fault_page <= pending_faults.pop_front();
            end else begin
               req_valid <= 1'b0;
               if (send_wait != 0) send_wait--;
            end
         end
      end
   end

   // Outcome monitor; also moves a fault's outcome to the owed list on its transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_outcome();
            if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
            hold_left = draw_wait(take_calm);
         end else if (rsp_valid && hold_left != 0) begin
            hold_left--;
         end
         if (req_valid && !req_stall && queued_outcomes.size() != 0)
            owed_outcomes.push_back(queued_outcomes.pop_front());
         rsp_stall <= (hold_left != 0);
      end
   end

   initial begin
      byte unsigned one_frame_walk[9] = '{0, 0, 0, 255, 255, 128, 1, 1, 1};
      byte unsigned one_frame_draws[5] = '{2, 85, 170, 2, 2};
      clear_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Single frame (count of zero), zero seed: grants, eviction with and without write-back
      write_csr(CSR_POLICY, SEED_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES, 0);
      write_csr(CSR_SEED, 0);
      foreach (one_frame_walk[i]) void'(try_fault(PAGE_W'(one_frame_walk[i])));
      drain(4);
      write_csr(CSR_POLICY, SEED_W'(POLICY_RANDOM));
      foreach (one_frame_draws[i]) void'(try_fault(PAGE_W'(one_frame_draws[i])));
      drain(4);

      // Fill the ring under FIFO with an oversized frame count
      write_csr(CSR_POLICY, SEED_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES, 127);
      random_faults(80, NUM_PAGES - 1);
      drain(4);

      write_csr(CSR_FRAMES, NUM_FRAMES - 1);
      random_faults(50, NUM_PAGES - 1);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_RANDOM));
      write_csr(CSR_FRAMES, NUM_FRAMES);
      write_csr(CSR_SEED, '1);
      random_faults(50, NUM_PAGES - 1);
      drain(4);

      write_csr(CSR_FRAMES, 5);
      write_csr(CSR_SEED, $urandom());
      random_faults(40, 15);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES, 8);
      random_faults(50, 20);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_RANDOM));
      write_csr(CSR_FRAMES, 1);
      random_faults(40, 4);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES, 2);
      random_faults(40, 6);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_RANDOM));
      write_csr(CSR_FRAMES, $urandom_range(1, NUM_FRAMES));
      write_csr(CSR_SEED, $urandom());
      random_faults(40, NUM_PAGES - 1);
      drain(4);

      write_csr(CSR_POLICY, SEED_W'(POLICY_FIFO));
      write_csr(CSR_FRAMES, $urandom_range(3, NUM_FRAMES - 1));
      random_faults(40, 80);
      drain(45);

      if (owed_outcomes.size() != 0)
         note_error($sformatf("%0d outcomes never arrived", owed_outcomes.size()));
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #(5_000_000);
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> page_fault_frame_replacer_top.f
+incdir+hdl
hdl/pffr_pkg.sv
hdl/pffr_page_table.sv
hdl/pffr_frame_table.sv
hdl/pffr_mod.sv
hdl/page_fault_frame_replacer_top.sv
verif/page_fault_frame_replacer_top_test.sv
